// ===== rtl/wabs_pkg.sv =====
// Package for the windowed average background subtract core.
// Holds widths, register indexes, reset values, controller states and command types.
// No dependencies.
`timescale 1ns / 1ps

package wabs_pkg;

  localparam int SMP_W     = 32;
  localparam int SUM_W     = 46;
  localparam int CNT_W     = 15;
  localparam int CFG_W     = 14;
  localparam int CH_W      = 3;
  localparam int Q_W       = 32;
  localparam int DIFF_W    = 33;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_SAMPLES_DEF = 16384;
  localparam int CHANNELS_DEF    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_FIRST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_LAST      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_FIRST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_LAST  = 2'd3;

  localparam logic [CFG_W-1:0] SIGNAL_FIRST_RST     = 14'd0;
  localparam logic [CFG_W-1:0] SIGNAL_LAST_RST      = 14'd100;
  localparam logic [CFG_W-1:0] BACKGROUND_FIRST_RST = 14'd1600;
  localparam logic [CFG_W-1:0] BACKGROUND_LAST_RST  = 14'd1650;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIG_START,
    ST_SIG_RUN,
    ST_BKG_START,
    ST_BKG_RUN,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic in_open;
    logic div_start;
    logic div_sel_bkg;
    logic cap_sig;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_taken;
    logic hit;
    logic div_done;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== rtl/wabs_div.sv =====
// Sequential signed divider: 46-bit sum by 15-bit count, one quotient bit per cycle.
// Truncates toward zero. Depends on wabs_pkg.
`timescale 1ns / 1ps

module wabs_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [wabs_pkg::SUM_W-1:0]   dividend,
  input  logic        [wabs_pkg::CNT_W-1:0]   divisor,
  output logic                                done,
  output logic signed [wabs_pkg::Q_W-1:0]     quotient
);
  import wabs_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dsr_r;
  logic              neg_r;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  quo_signed;

  assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

  always_comb begin
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    rem_nxt  = ge ? CNT_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[CNT_W-1:0];
    quo_nxt  = {quo_r[SUM_W-2:0], ge};
    busy_nxt = busy_r && (step_r != STEP_W'(SUM_W - 1));
    done_nxt = busy_r && (step_r == STEP_W'(SUM_W - 1));
    step_nxt = step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) begin
        step_r <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      dsr_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient   = signed'(quo_signed[Q_W-1:0]);
  assign done       = done_r;

endmodule

// ===== rtl/wabs_dp.sv =====
// Datapath: window registers, index and accumulators, waveform snapshot, divider and
// output register. Depends on wabs_pkg and wabs_div.
`timescale 1ns / 1ps

module wabs_dp #(
  parameter int MAX_SAMPLES = wabs_pkg::MAX_SAMPLES_DEF,
  parameter int CHANNELS    = wabs_pkg::CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic [wabs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wabs_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  input  logic [wabs_pkg::CH_W-1:0]             in_channel,
  input  logic signed [wabs_pkg::SMP_W-1:0]     in_sample,
  input  logic                                  in_last_sample,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [wabs_pkg::CH_W-1:0]             out_result_channel,
  output logic signed [wabs_pkg::DIFF_W-1:0]    out_mean_difference,
  output logic                                  out_both_windows_hit,
  input  wabs_pkg::ctrl_cmd_t                   cmd,
  output wabs_pkg::ctrl_status_t                status
);
  import wabs_pkg::*;

  localparam int IDX_W    = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W    = (IDX_W > CFG_W) ? IDX_W : CFG_W;
  localparam int CH_LIM_W = ($clog2(CHANNELS + 1) > CH_W) ? $clog2(CHANNELS + 1) : CH_W;

  logic [CFG_W-1:0]        sig_first_r, sig_last_r, bkg_first_r, bkg_last_r;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic signed [SUM_W-1:0] sig_sum_r, bkg_sum_r, sig_sum_nxt, bkg_sum_nxt;
  logic [CNT_W-1:0]        sig_cnt_r, bkg_cnt_r, sig_cnt_nxt, bkg_cnt_nxt;
  logic signed [SUM_W-1:0] smp_ext;
  logic [CMP_W-1:0]        idx_ext;
  logic                    live, sig_win, bkg_win, chan_ok, take;

  logic signed [SUM_W-1:0] snap_sig_sum_r, snap_bkg_sum_r;
  logic [CNT_W-1:0]        snap_sig_cnt_r, snap_bkg_cnt_r;
  logic [CH_W-1:0]         snap_chan_r;
  logic                    snap_hit_r;

  logic signed [SUM_W-1:0] div_dividend;
  logic [CNT_W-1:0]        div_divisor;
  logic                    div_done;
  logic signed [Q_W-1:0]   div_q;
  logic signed [Q_W-1:0]   q_sig_r;

  logic                     out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]          out_chan_r;
  logic signed [DIFF_W-1:0] out_diff_r, out_diff_nxt;
  logic                     out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_first_r <= SIGNAL_FIRST_RST;
      sig_last_r  <= SIGNAL_LAST_RST;
      bkg_first_r <= BACKGROUND_FIRST_RST;
      bkg_last_r  <= BACKGROUND_LAST_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIGNAL_FIRST:     sig_first_r <= cfg_data;
        REG_SIGNAL_LAST:      sig_last_r  <= cfg_data;
        REG_BACKGROUND_FIRST: bkg_first_r <= cfg_data;
        REG_BACKGROUND_LAST:  bkg_last_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    chan_ok = CH_LIM_W'(in_channel) < CH_LIM_W'(CHANNELS);
    take    = in_valid && cmd.in_open && chan_ok;
    smp_ext = SUM_W'(in_sample);
    idx_ext = CMP_W'(idx_r);
    live    = idx_r < IDX_W'(MAX_SAMPLES);
    sig_win = live && (idx_ext >= CMP_W'(sig_first_r)) && (idx_ext <= CMP_W'(sig_last_r));
    bkg_win = live && (idx_ext >= CMP_W'(bkg_first_r)) && (idx_ext <= CMP_W'(bkg_last_r));
    sig_sum_nxt = sig_sum_r + (sig_win ? smp_ext : '0);
    bkg_sum_nxt = bkg_sum_r + (bkg_win ? smp_ext : '0);
    sig_cnt_nxt = sig_cnt_r + CNT_W'(sig_win);
    bkg_cnt_nxt = bkg_cnt_r + CNT_W'(bkg_win);
    idx_nxt     = live ? (idx_r + 1'b1) : idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      sig_sum_r <= '0;
      bkg_sum_r <= '0;
      sig_cnt_r <= '0;
      bkg_cnt_r <= '0;
    end else if (take) begin
      if (in_last_sample) begin
        idx_r     <= '0;
        sig_sum_r <= '0;
        bkg_sum_r <= '0;
        sig_cnt_r <= '0;
        bkg_cnt_r <= '0;
      end else begin
        idx_r     <= idx_nxt;
        sig_sum_r <= sig_sum_nxt;
        bkg_sum_r <= bkg_sum_nxt;
        sig_cnt_r <= sig_cnt_nxt;
        bkg_cnt_r <= bkg_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last_sample) begin
      snap_sig_sum_r <= sig_sum_nxt;
      snap_bkg_sum_r <= bkg_sum_nxt;
      snap_sig_cnt_r <= sig_cnt_nxt;
      snap_bkg_cnt_r <= bkg_cnt_nxt;
      snap_chan_r    <= in_channel;
      snap_hit_r     <= (sig_cnt_nxt != '0) && (bkg_cnt_nxt != '0);
    end
    if (cmd.cap_sig) begin
      q_sig_r <= div_q;
    end
  end

  assign div_dividend = cmd.div_sel_bkg ? snap_bkg_sum_r : snap_sig_sum_r;
  assign div_divisor  = cmd.div_sel_bkg ? snap_bkg_cnt_r : snap_sig_cnt_r;

  wabs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    out_diff_nxt  = snap_hit_r ? (DIFF_W'(q_sig_r) - DIFF_W'(div_q)) : '0;
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_chan_r <= snap_chan_r;
      out_diff_r <= out_diff_nxt;
      out_hit_r  <= snap_hit_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_channel   = out_chan_r;
  assign out_mean_difference  = out_diff_r;
  assign out_both_windows_hit = out_hit_r;

  always_comb begin
    status.last_taken = take && in_last_sample;
    status.hit        = snap_hit_r;
    status.div_done   = div_done;
    status.out_free   = !out_valid_r || !out_stall;
  end

endmodule

// ===== rtl/wabs_ctrl.sv =====
// Controller: sequences sample intake, the two mean divisions and the result load.
// Depends on wabs_pkg.
`timescale 1ns / 1ps

module wabs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wabs_pkg::ctrl_status_t status,
  output wabs_pkg::ctrl_cmd_t    cmd
);
  import wabs_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (status.last_taken) state_nxt = ST_SIG_START;
      ST_SIG_START: state_nxt = status.hit ? ST_SIG_RUN : ST_OUT;
      ST_SIG_RUN:   if (status.div_done) state_nxt = ST_BKG_START;
      ST_BKG_START: state_nxt = ST_BKG_RUN;
      ST_BKG_RUN:   if (status.div_done) state_nxt = ST_OUT;
      ST_OUT:       if (status.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:      cmd.in_open = 1'b1;
      ST_SIG_START: cmd.div_start = status.hit;
      ST_SIG_RUN:   cmd.cap_sig = status.div_done;
      ST_BKG_START: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_bkg = 1'b1;
      end
      ST_BKG_RUN:   cmd.div_sel_bkg = 1'b1;
      ST_OUT:       cmd.out_load = status.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

// ===== rtl/windowed_average_background_subtract_core.sv =====
// Top level of the windowed average background subtract core.
// Depends on wabs_pkg, wabs_ctrl, wabs_dp (which holds wabs_div).
//
// Usage: samples of one waveform enter on the in_ channel (valid/stall), one
// transaction per cycle while in_stall is low, in order; in_last_sample marks the
// final one. Samples whose running index falls in the signal or background window
// (inclusive, set through the cfg_ write channel) are summed and counted. Indexes at
// or past MAX_SAMPLES are not accumulated. Transactions with a channel at or above
// CHANNELS are taken and ignored. After the last sample the input stalls while the two
// means are formed in turn by one shared bit-serial divider; then the result appears
// on the out_ channel (with no division when a window is empty, which yields 0 with
// both_windows_hit low). Non-last samples never stall the input.
// The result sits in an output register; if out_stall holds it, the next waveform's
// samples are still taken, and after its last sample the input stalls until that
// register frees.
// Reset (rst_n low, synchronous) restores window defaults 0..100 and 1600..1650 and
// clears index, sums, counts and the output valid. cfg_ready is always high; write
// the windows only while no waveform is in progress.
`timescale 1ns / 1ps

module windowed_average_background_subtract_core #(
  parameter int MAX_SAMPLES = wabs_pkg::MAX_SAMPLES_DEF,
  parameter int CHANNELS    = wabs_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wabs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wabs_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wabs_pkg::CH_W-1:0]           in_channel,
  input  logic signed [wabs_pkg::SMP_W-1:0]   in_sample,
  input  logic                                in_last_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wabs_pkg::CH_W-1:0]           out_result_channel,
  output logic signed [wabs_pkg::DIFF_W-1:0]  out_mean_difference,
  output logic                                out_both_windows_hit
);
  import wabs_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;
  assign in_stall  = !cmd.in_open;

  wabs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  wabs_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CHANNELS    (CHANNELS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_channel           (in_channel),
    .in_sample            (in_sample),
    .in_last_sample       (in_last_sample),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_result_channel   (out_result_channel),
    .out_mean_difference  (out_mean_difference),
    .out_both_windows_hit (out_both_windows_hit),
    .cmd                  (cmd),
    .status               (status)
  );

  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    status.last_taken |=> in_stall)
    else $error("input not stalled after last sample");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result shown without a load");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_both_windows_hit) |-> (out_mean_difference == '0))
    else $error("nonzero difference with an empty window");

  a_no_div_while_open: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.in_open |-> !cmd.div_start)
    else $error("division started while taking samples");

endmodule
